[hw/rtl/sddf_pkg.sv]
// types and constants shared by the signed decimal digit formatter
// no dependencies

package sddf_pkg;

  localparam int          MAG_W      = 32;
  localparam int          CODE_W     = 4;
  localparam int          ADDR_W     = 4;

  localparam logic [CODE_W-1:0] CODE_MINUS = 4'hA;
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'hF;

  // divide by ten: q = (m * RECIP_10) >> QUOT_SHIFT, exact for all 32-bit m
  localparam logic [MAG_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int               QUOT_SHIFT = 35;
  localparam int               QUOT_W     = 2 * MAG_W - QUOT_SHIFT;

  typedef struct packed {
    logic              valid;
    logic              minus;
    logic [MAG_W-1:0]  mag;
  } cell_state_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } digit_out_t;

endpackage

[hw/rtl/sddf_cell.sv]
// one display position: holds the remaining magnitude and minus flag,
// emits its digit code and hands the quotient by ten to the next cell
// depends on sddf_pkg

module sddf_cell import sddf_pkg::*; #(
  parameter bit IS_LOWEST = 1'b0
) (
  input  logic        clk,
  input  logic        rst,
  input  cell_state_t din,
  output cell_state_t dout,
  output digit_out_t  dig
);

  cell_state_t          st;
  logic [2*MAG_W-1:0]   prod;
  logic [QUOT_W-1:0]    quot;
  logic [CODE_W-1:0]    rem;
  logic                 show_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      st.valid <= din.valid;
    end
    st.minus <= din.minus;
    st.mag   <= din.mag;
  end

  always_comb begin
    prod       = {{MAG_W{1'b0}}, st.mag} * {{MAG_W{1'b0}}, RECIP_10};
    quot       = prod[2*MAG_W-1:QUOT_SHIFT];
    // remainder below ten, so the low four bits suffice
    rem        = st.mag[CODE_W-1:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
    show_digit = IS_LOWEST || (st.mag != '0);

    dig.valid = st.valid;
    if (show_digit) begin
      dig.code = rem;
    end else if (st.minus) begin
      dig.code = CODE_MINUS;
    end else begin
      dig.code = CODE_BLANK;
    end

    dout.valid = st.valid;
    dout.minus = st.minus && show_digit;
    dout.mag   = {{(MAG_W-QUOT_W){1'b0}}, quot};
  end

endmodule

[hw/rtl/signed_decimal_digit_formatter.sv]
// top level of the signed decimal digit formatter: a row of digit cells
// and the output word register
// depends on sddf_pkg and sddf_cell
//
// usage:
//   drive number and raise start; the word is taken at a clock edge where
//   start is high and busy is low. the block then emits DIGITS words, one
//   per cycle, lowest position first: reg_address 1..DIGITS, digit_code
//   0-9 digit, 10 minus, 15 blank, last high on the final word. each word
//   is valid for exactly one cycle while strobe is high; the receiver
//   cannot stall the block and must take every word as it comes.
//   the accepted number is held in the lowest cell's register, and its
//   first word then passes the output register to reach the outputs.
//   busy drops during the cycle the top cell works, so a new number is
//   taken while the last words of the previous one are still leaving
//   and the words run with no gap. each cell does one divide by ten (a
//   32x32 multiply by the reciprocal), so one position moves per cycle
//   along the row.
//   reset clears all cell valid flags and strobe; a number in flight is
//   dropped.

module signed_decimal_digit_formatter import sddf_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   number,
  output logic                 busy,
  output logic                 strobe,
  output logic [ADDR_W-1:0]    reg_address,
  output logic [CODE_W-1:0]    digit_code,
  output logic                 last
);

  cell_state_t              chain [DIGITS+1];
  digit_out_t               dig   [DIGITS];
  logic [MAG_W-1:0]         raw;
  logic                     strobe_next;
  logic [ADDR_W-1:0]        reg_address_next;
  logic [CODE_W-1:0]        digit_code_next;
  logic                     last_next;

  assign raw = number;

  always_comb begin
    busy = 1'b0;
    for (int k = 0; k < DIGITS - 1; k++) begin
      busy = busy | dig[k].valid;
    end
  end

  assign chain[0].valid = start && !busy;
  assign chain[0].minus = raw[MAG_W-1];
  assign chain[0].mag   = raw[MAG_W-1] ? ('0 - raw) : raw;

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    sddf_cell #(
      .IS_LOWEST(k == 0)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .din (chain[k]),
      .dout(chain[k+1]),
      .dig (dig[k])
    );
  end

  always_comb begin
    strobe_next      = 1'b0;
    reg_address_next = '0;
    digit_code_next  = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (dig[k].valid) begin
        strobe_next      = 1'b1;
        reg_address_next = ADDR_W'(k + 1);
        digit_code_next  = dig[k].code;
      end
    end
    last_next = chain[DIGITS].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    reg_address <= reg_address_next;
    digit_code  <= digit_code_next;
    last        <= last_next;
  end

`ifndef NO_ASSERTIONS
  logic [DIGITS-1:0] cell_active;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      cell_active[k] = dig[k].valid;
    end
  end

  a_one_cell_active: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_active))
    else $error("more than one cell active");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 (strobe && reg_address == ADDR_W'(1)))
    else $error("first word missing after accept");

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (strobe && reg_address == $past(reg_address) + ADDR_W'(1)))
    else $error("word run broken");

  a_last_address: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (reg_address == ADDR_W'(DIGITS)))
    else $error("last flag on wrong position");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_code <= 4'd9 || digit_code == CODE_MINUS || digit_code == CODE_BLANK))
    else $error("illegal digit code");
`endif

endmodule
